### rtl/mrcrr_pkg.sv
`default_nettype none
package mrcrr_pkg;

  localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
  localparam logic [7:0]  RESP_BYTE_COUNT = 8'h02;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

  // configuration register indexes
  localparam logic [2:0] REG_DEVICE_ADDRESS   = 3'd0;
  localparam logic [2:0] REG_RESPONDER_ENABLE = 3'd1;
  localparam logic [2:0] REG_MATCH_REGISTER   = 3'd2;
  localparam logic [2:0] REG_MATCH_QUANTITY   = 3'd3;
  localparam logic [2:0] REG_REPLY_VALUE      = 3'd4;

  // request frame positions
  localparam logic [3:0] POS_ADDR    = 4'd0;
  localparam logic [3:0] POS_FUNC    = 4'd1;
  localparam logic [3:0] POS_REG_HI  = 4'd2;
  localparam logic [3:0] POS_REG_LO  = 4'd3;
  localparam logic [3:0] POS_QTY_HI  = 4'd4;
  localparam logic [3:0] POS_QTY_LO  = 4'd5;
  localparam logic [3:0] POS_CRC_LO  = 4'd6;
  localparam logic [3:0] POS_CRC_HI  = 4'd7;

  // response byte slots
  localparam logic [2:0] TX_ADDR    = 3'd0;
  localparam logic [2:0] TX_FUNC    = 3'd1;
  localparam logic [2:0] TX_COUNT   = 3'd2;
  localparam logic [2:0] TX_VAL_HI  = 3'd3;
  localparam logic [2:0] TX_VAL_LO  = 3'd4;
  localparam logic [2:0] TX_CRC_LO  = 3'd5;
  localparam logic [2:0] TX_CRC_HI  = 3'd6;

  typedef struct packed {
    logic [7:0]  device_address;
    logic        responder_enable;
    logic [15:0] match_register;
    logic [15:0] match_quantity;
    logic [15:0] reply_value;
  } cfg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/modbus_rtu_check_request_responder.sv
`default_nettype none
// Channel   Direction  Width  Contents
// s_axis    in         8      rx_byte
// m_axis    out        24+1   tx_byte, responses_sent; tlast = last_byte
// cfg       in         3/16   register index, write data
//
// One received byte is taken per cycle while s_tready is high; the parser state advances on the same edge.
// A good frame raises m_tvalid after its last CRC byte is taken, through the start register
// (frame check) and the busy register (response load); its 7 bytes then leave one per cycle
// while m_tready is high. While a response is pending or going out, the last CRC byte of the
// next frame is held off (s_tready low).
// Reset (rst, synchronous) returns the parser to idle, the count to zero and the registers.
module modbus_rtu_check_request_responder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,    // rx_byte[7:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,    // tx_byte[7:0], responses_sent[23:8]
  output logic             m_tlast,    // last_byte
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  mrcrr_pkg::cfg_t cfg;
  logic [3:0]      frame_position;
  logic            start;
  logic            busy;
  logic            in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address   <= 8'd1;
      cfg.responder_enable <= 1'b0;
      cfg.match_register   <= 16'h0080;
      cfg.match_quantity   <= 16'h0001;
      cfg.reply_value      <= 16'h0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mrcrr_pkg::REG_DEVICE_ADDRESS:   cfg.device_address   <= cfg_data[7:0];
        mrcrr_pkg::REG_RESPONDER_ENABLE: cfg.responder_enable <= cfg_data[0];
        mrcrr_pkg::REG_MATCH_REGISTER:   cfg.match_register   <= cfg_data;
        mrcrr_pkg::REG_MATCH_QUANTITY:   cfg.match_quantity   <= cfg_data;
        mrcrr_pkg::REG_REPLY_VALUE:      cfg.reply_value      <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold the closing byte until the pending or previous response has left
  assign s_tready = !((busy || start) && frame_position == mrcrr_pkg::POS_CRC_HI);
  assign in_fire  = s_tvalid && s_tready;
  assign m_tvalid = busy;

  mrcrr_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_fire        (in_fire),
    .in_byte        (s_tdata),
    .frame_position (frame_position),
    .start          (start)
  );

  mrcrr_responder u_responder (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .start  (start),
    .busy   (busy),
    .tdata  (m_tdata),
    .tlast  (m_tlast),
    .tready (m_tready)
  );

endmodule
`default_nettype wire

### rtl/mrcrr_parser.sv
`default_nettype none
module mrcrr_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mrcrr_pkg::cfg_t    cfg,
  input  wire logic               in_fire,
  input  wire logic [7:0]         in_byte,
  output logic [3:0]              frame_position,
  output logic                    start
);

  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  received_crc_low, received_crc_low_next;
  logic [3:0]  frame_position_next;
  logic        start_next;
  logic [7:0]  expect_byte;
  logic        addr_hit;

  assign addr_hit = (in_byte == cfg.device_address);

  always_comb begin
    case (frame_position)
      mrcrr_pkg::POS_FUNC:   expect_byte = mrcrr_pkg::FN_READ_HOLDING;
      mrcrr_pkg::POS_REG_HI: expect_byte = cfg.match_register[15:8];
      mrcrr_pkg::POS_REG_LO: expect_byte = cfg.match_register[7:0];
      mrcrr_pkg::POS_QTY_HI: expect_byte = cfg.match_quantity[15:8];
      default:               expect_byte = cfg.match_quantity[7:0];
    endcase
  end

  always_comb begin
    running_crc_next      = running_crc;
    received_crc_low_next = received_crc_low;
    frame_position_next   = frame_position;
    start_next            = 1'b0;
    if (in_fire) begin
      if (frame_position == mrcrr_pkg::POS_CRC_LO) begin
        received_crc_low_next = in_byte;
        frame_position_next   = mrcrr_pkg::POS_CRC_HI;
      end else if (frame_position == mrcrr_pkg::POS_CRC_HI) begin
        frame_position_next = mrcrr_pkg::POS_ADDR;
        running_crc_next    = mrcrr_pkg::CRC_INIT;
        start_next = cfg.responder_enable && (running_crc == {in_byte, received_crc_low});
      end else if (frame_position != mrcrr_pkg::POS_ADDR && frame_position < mrcrr_pkg::POS_CRC_LO
                   && in_byte == expect_byte) begin
        running_crc_next    = mrcrr_pkg::crc_byte(running_crc, in_byte);
        frame_position_next = frame_position + 4'd1;
      end else if (addr_hit) begin
        // idle, out of range or mismatch: an address byte opens a new frame
        running_crc_next    = mrcrr_pkg::crc_byte(mrcrr_pkg::CRC_INIT, in_byte);
        frame_position_next = mrcrr_pkg::POS_FUNC;
      end else begin
        running_crc_next    = mrcrr_pkg::CRC_INIT;
        frame_position_next = mrcrr_pkg::POS_ADDR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position   <= mrcrr_pkg::POS_ADDR;
      running_crc      <= mrcrr_pkg::CRC_INIT;
      received_crc_low <= 8'h00;
      start            <= 1'b0;
    end else begin
      frame_position   <= frame_position_next;
      running_crc      <= running_crc_next;
      received_crc_low <= received_crc_low_next;
      start            <= start_next;
    end
  end

endmodule
`default_nettype wire

### rtl/mrcrr_responder.sv
`default_nettype none
module mrcrr_responder (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mrcrr_pkg::cfg_t    cfg,
  input  wire logic               start,
  output logic                    busy,
  output logic [23:0]             tdata,   // tx_byte[7:0], responses_sent[23:8]
  output logic                    tlast,   // last_byte
  input  wire logic               tready
);

  logic [2:0]  slot, slot_next;
  logic [15:0] tx_crc, tx_crc_next;
  logic [15:0] response_counter, response_counter_next;
  logic        busy_next;
  logic [7:0]  tx_byte;
  logic        beat;

  assign beat = busy && tready;

  always_comb begin
    unique case (slot)
      mrcrr_pkg::TX_ADDR:   tx_byte = cfg.device_address;
      mrcrr_pkg::TX_FUNC:   tx_byte = mrcrr_pkg::FN_READ_HOLDING;
      mrcrr_pkg::TX_COUNT:  tx_byte = mrcrr_pkg::RESP_BYTE_COUNT;
      mrcrr_pkg::TX_VAL_HI: tx_byte = cfg.reply_value[15:8];
      mrcrr_pkg::TX_VAL_LO: tx_byte = cfg.reply_value[7:0];
      mrcrr_pkg::TX_CRC_LO: tx_byte = tx_crc[7:0];
      default:              tx_byte = tx_crc[15:8];
    endcase
  end

  assign tdata = {response_counter, tx_byte};
  assign tlast = (slot == mrcrr_pkg::TX_CRC_HI);

  always_comb begin
    slot_next             = slot;
    tx_crc_next           = tx_crc;
    response_counter_next = response_counter;
    busy_next             = busy;
    if (start && !busy) begin
      busy_next   = 1'b1;
      slot_next   = mrcrr_pkg::TX_ADDR;
      tx_crc_next = mrcrr_pkg::CRC_INIT;
      if (response_counter != mrcrr_pkg::COUNT_MAX) begin
        response_counter_next = response_counter + 16'd1;
      end
    end else if (beat) begin
      // fold the address, function, count and value bytes into the CRC as they leave
      if (slot < mrcrr_pkg::TX_CRC_LO) begin
        tx_crc_next = mrcrr_pkg::crc_byte(tx_crc, tx_byte);
      end
      if (slot == mrcrr_pkg::TX_CRC_HI) begin
        busy_next = 1'b0;
      end else begin
        slot_next = slot + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy             <= 1'b0;
      slot             <= mrcrr_pkg::TX_ADDR;
      response_counter <= 16'h0000;
    end else begin
      busy             <= busy_next;
      slot             <= slot_next;
      response_counter <= response_counter_next;
    end
    tx_crc <= tx_crc_next;
  end

endmodule
`default_nettype wire
